// File: rtl/wsus_pkg.sv
// Package with shared types, constants and the scheme table of the websocket URL splitter.
`timescale 1ns / 1ps
`default_nettype none

package wsus_pkg;

    // Byte classification codes carried on byte_kind.
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_HOST  = 2'd1;
    localparam logic [1:0] KIND_PORT  = 2'd2;
    localparam logic [1:0] KIND_PATH  = 2'd3;

    localparam logic [16:0] PORT_MAX      = 17'd65535;
    localparam logic [16:0] PORT_DEF_WS   = 17'd80;
    localparam logic [16:0] PORT_DEF_WSS  = 17'd443;
    localparam logic [2:0]  SCHEME_LEN_WS  = 3'd5;
    localparam logic [2:0]  SCHEME_LEN_WSS = 3'd6;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_W     = 8'h77;

    typedef enum logic [2:0] {
        PH_SCHEME = 3'd0,
        PH_HOST   = 3'd1,
        PH_PORT   = 3'd2,
        PH_PATH   = 3'd3,
        PH_FAIL   = 3'd4
    } wsus_phase_t;

    typedef enum logic [1:0] {
        PP_SKIP   = 2'd0,
        PP_DIGITS = 2'd1,
        PP_DONE   = 2'd2
    } wsus_pphase_t;

    // State of the port number reader.
    typedef struct packed {
        wsus_pphase_t pphase;
        logic         negative;
        logic [16:0]  accum;
    } wsus_port_t;

    // Whole per-URL parser state.
    typedef struct packed {
        wsus_phase_t phase;
        logic [2:0]  scheme_pos;
        logic        secure;
        wsus_port_t  port;
    } wsus_state_t;

    // Parser state after reset and after the last byte of a URL.
    localparam wsus_state_t ST_RESET = '{
        phase:      PH_SCHEME,
        scheme_pos: 3'd0,
        secure:     1'b0,
        port:       '{pphase: PP_SKIP, negative: 1'b0, accum: 17'd0}
    };

    // Expected scheme byte at a position, for plain and secure schemes.
    function automatic logic [7:0] scheme_char(input logic secure, input logic [2:0] pos);
        logic [7:0] ch;
        begin
            ch = 8'h00;
            if (secure)
            begin
                unique case (pos)
                    3'd0:    ch = CH_W;
                    3'd1:    ch = CH_S;
                    3'd2:    ch = CH_S;
                    3'd3:    ch = CH_COLON;
                    3'd4:    ch = CH_SLASH;
                    3'd5:    ch = CH_SLASH;
                    default: ch = 8'h00;
                endcase
            end
            else
            begin
                unique case (pos)
                    3'd0:    ch = CH_W;
                    3'd1:    ch = CH_S;
                    3'd2:    ch = CH_COLON;
                    3'd3:    ch = CH_SLASH;
                    3'd4:    ch = CH_SLASH;
                    default: ch = 8'h00;
                endcase
            end
            return ch;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/websocket_url_splitter_core.sv
// Top level of the websocket URL splitter: input register, step logic and result register.
`timescale 1ns / 1ps
`default_nettype none

// The splitter takes a websocket URL one byte per beat, the final byte marked by
// is_last, and returns one result beat for every input beat, in order. The URL
// must open with ws:// (default port 80) or wss:// (default port 443, tls_on set).
// Each byte comes back on char_out with byte_kind: 0 for scheme, delimiters and
// anything after a bad scheme, 1 for host, 2 for port text, 3 for the path
// (including the slash that opens it). The port text is read as atoi would read
// it, with the magnitude held at 65535; port text without digits gives 0. On the
// beat flagged url_end, parse_ok, tls_on and port_number report the outcome; on
// every other beat, and for a malformed URL, they are zero. After the last byte
// the parser is back at its reset state, ready for the next URL.
// Throughput is one byte per clock cycle while the output side does not stall:
// the only feedback is the small parser state, updated in the same cycle as a
// byte moves from the input register to the result register. A result beat
// passes through the input register and then the result register, and an
// output stall can hold it in either. in_ready depends on out_ready through the
// two-entry pipeline, so both registers stay full while the output side stalls.
module websocket_url_splitter_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        char_in,
    input  wire logic              is_last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             char_out,
    output logic [1:0]             byte_kind,
    output logic                   url_end,
    output logic                   parse_ok,
    output logic                   tls_on,
    output logic signed [16:0]     port_number
);
    import wsus_pkg::*;

    // Input register.
    logic        ivalid_reg;
    logic [7:0]  ichar_reg;
    logic        ilast_reg;

    // Parser state.
    wsus_state_t st_reg;
    wsus_state_t st_next;

    // Result register.
    logic               ovalid_reg;
    logic [7:0]         ochar_reg;
    logic [1:0]         okind_reg;
    logic               oend_reg;
    logic               ook_reg;
    logic               otls_reg;
    logic signed [16:0] oport_reg;

    logic               advance;
    logic [1:0]         kind_next;
    logic               ok_next;
    logic               tls_next;
    logic signed [16:0] port_next;

    // A byte moves on when the result register is empty or being emptied.
    assign advance  = ivalid_reg && (!ovalid_reg || out_ready);
    assign in_ready = !ivalid_reg || advance;

    wsus_step u_step (
        .ch       (ichar_reg),
        .last     (ilast_reg),
        .st_cur   (st_reg),
        .st_next  (st_next),
        .kind     (kind_next),
        .ok       (ok_next),
        .tls      (tls_next),
        .port_val (port_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ivalid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ichar_reg <= char_in;
            ilast_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ochar_reg <= ichar_reg;
            okind_reg <= kind_next;
            oend_reg  <= ilast_reg;
            ook_reg   <= ok_next;
            otls_reg  <= tls_next;
            oport_reg <= port_next;
        end
    end

    assign out_valid   = ovalid_reg;
    assign char_out    = ochar_reg;
    assign byte_kind   = okind_reg;
    assign url_end     = oend_reg;
    assign parse_ok    = ook_reg;
    assign tls_on      = otls_reg;
    assign port_number = oport_reg;

endmodule

`default_nettype wire

// File: rtl/wsus_port_reader.sv
// Port number reader: whitespace skip, optional sign and saturating decimal accumulation.
`timescale 1ns / 1ps
`default_nettype none

module wsus_port_reader (
    input  wire logic [7:0]          ch,
    input  wire wsus_pkg::wsus_port_t port_cur,
    output wsus_pkg::wsus_port_t     port_next
);
    import wsus_pkg::*;

    logic        is_digit;
    logic        is_space;
    logic        is_sign;
    logic [19:0] acc_wide;
    logic [16:0] acc_sat;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

    // Times ten as two shifts and an add; the old value never exceeds 65535.
    assign acc_wide = {port_cur.accum, 3'b000} + {2'b00, port_cur.accum, 1'b0}
                    + {12'd0, ch - CH_ZERO};
    assign acc_sat  = (acc_wide > {3'b000, PORT_MAX}) ? PORT_MAX : acc_wide[16:0];

    always_comb
    begin
        port_next = port_cur;
        unique case (port_cur.pphase)
            PP_SKIP:
            begin
                priority if (is_space)
                begin
                    port_next = port_cur;
                end
                else if (is_sign)
                begin
                    port_next.negative = (ch == CH_MINUS);
                    port_next.pphase   = PP_DIGITS;
                end
                else if (is_digit)
                begin
                    port_next.pphase = PP_DIGITS;
                    port_next.accum  = acc_sat;
                end
                else
                begin
                    port_next.pphase = PP_DONE;
                end
            end
            PP_DIGITS:
            begin
                if (is_digit)
                begin
                    port_next.accum = acc_sat;
                end
                else
                begin
                    port_next.pphase = PP_DONE;
                end
            end
            default:
            begin
                port_next = port_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/wsus_step.sv
// Per-byte step logic: scheme match, host/port/path tagging and the end-of-URL summary.
`timescale 1ns / 1ps
`default_nettype none

module wsus_step (
    input  wire logic [7:0]          ch,
    input  wire logic                last,
    input  wire wsus_pkg::wsus_state_t st_cur,
    output wsus_pkg::wsus_state_t    st_next,
    output logic [1:0]               kind,
    output logic                     ok,
    output logic                     tls,
    output logic signed [16:0]       port_val
);
    import wsus_pkg::*;

    wsus_port_t  port_upd;
    wsus_state_t st_adv;
    logic        sec_now;
    logic        match;
    logic [2:0]  pos_inc;

    wsus_port_reader u_port (
        .ch        (ch),
        .port_cur  (st_cur.port),
        .port_next (port_upd)
    );

    // An 's' at the third place selects the secure scheme.
    assign sec_now = st_cur.secure || ((st_cur.scheme_pos == 3'd2) && (ch == CH_S));
    assign match   = ((st_cur.scheme_pos == 3'd2) && (ch == CH_S))
                   || ((st_cur.scheme_pos < SCHEME_LEN_WSS)
                       && (ch == scheme_char(st_cur.secure, st_cur.scheme_pos)));
    assign pos_inc = st_cur.scheme_pos + 3'd1;

    // Next state.
    always_comb
    begin
        st_adv = st_cur;
        unique case (st_cur.phase)
            PH_SCHEME:
            begin
                if (!match)
                begin
                    st_adv.phase = PH_FAIL;
                end
                else
                begin
                    st_adv.secure     = sec_now;
                    st_adv.scheme_pos = pos_inc;
                    if (pos_inc == (sec_now ? SCHEME_LEN_WSS : SCHEME_LEN_WS))
                    begin
                        st_adv.phase      = PH_HOST;
                        st_adv.port.accum = sec_now ? PORT_DEF_WSS : PORT_DEF_WS;
                    end
                end
            end
            PH_HOST:
            begin
                if (ch == CH_COLON)
                begin
                    st_adv.phase         = PH_PORT;
                    st_adv.port.accum    = '0;
                    st_adv.port.negative = 1'b0;
                    st_adv.port.pphase   = PP_SKIP;
                end
                else if (ch == CH_SLASH)
                begin
                    st_adv.phase = PH_PATH;
                end
            end
            PH_PORT:
            begin
                if (ch == CH_SLASH)
                begin
                    st_adv.phase = PH_PATH;
                end
                else
                begin
                    st_adv.port = port_upd;
                end
            end
            default:
            begin
                st_adv = st_cur;
            end
        endcase

        if (last)
        begin
            st_next            = '0;
            st_next.phase      = PH_SCHEME;
            st_next.port.pphase = PP_SKIP;
        end
        else
        begin
            st_next = st_adv;
        end
    end

    // Outputs.
    always_comb
    begin
        kind = KIND_OTHER;
        unique case (st_cur.phase)
            PH_HOST:
            begin
                if (ch == CH_SLASH)
                begin
                    kind = KIND_PATH;
                end
                else if (ch != CH_COLON)
                begin
                    kind = KIND_HOST;
                end
            end
            PH_PORT:
            begin
                kind = (ch == CH_SLASH) ? KIND_PATH : KIND_PORT;
            end
            PH_PATH:
            begin
                kind = KIND_PATH;
            end
            default:
            begin
                kind = KIND_OTHER;
            end
        endcase

        ok       = last && (st_adv.phase == PH_PATH);
        tls      = ok && st_adv.secure;
        port_val = '0;
        if (ok)
        begin
            port_val = st_adv.port.negative ? -$signed(st_adv.port.accum)
                                            : $signed(st_adv.port.accum);
        end
    end

endmodule

`default_nettype wire

// File: rtl/wsus_checker.sv
// Port-level checker for the websocket URL splitter and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wsus_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_ready,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [7:0]        char_out,
    input  wire logic [1:0]        byte_kind,
    input  wire logic              url_end,
    input  wire logic              parse_ok,
    input  wire logic              tls_on,
    input  wire logic signed [16:0] port_number
);
    import wsus_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(byte_kind)
                                    && $stable(url_end) && $stable(port_number))
        else $error("result beat changed while stalled");

    // Summary fields are quiet away from the end of a URL.
    a_summary_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !url_end |-> !parse_ok && !tls_on && (port_number == 17'sd0))
        else $error("summary fields set before url_end");

    // A beat without parse_ok, as on a failed URL, carries no tls_on and no port.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !parse_ok |-> !tls_on && (port_number == 17'sd0))
        else $error("failed URL carries tls or port");

    // A well-formed URL always ends inside its path.
    a_ok_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && url_end && parse_ok |-> byte_kind == KIND_PATH)
        else $error("parse_ok on a byte outside the path");

    // The input side only pushes back while a result beat is waiting and stalled.
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without a stalled result beat");

endmodule

bind websocket_url_splitter_core wsus_checker u_wsus_checker (.*);

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the websocket URL splitter core.
`timescale 1ns / 1ps

// URLs are sent one byte per input beat, the final byte marked by is_last.
// A scoreboard keeps its own copy of the parser state and works out the tagged
// byte that each accepted input beat should produce. Every result beat is
// compared field by field with the oldest outstanding prediction.
// The sender works in bursts with random gaps between them. The receiver
// changes between several stall patterns, and once holds off for a long
// stretch so that both pipeline registers fill and in_ready drops.
module tb;
    import wsus_pkg::*;

    localparam int unsigned ITEM_TARGET  = 1950;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam string WS_PREFIX  = "ws://";
    localparam string WSS_PREFIX = "wss://";

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_t;

    // One predicted result beat.
    typedef struct packed {
        logic [7:0]         ch;
        logic [1:0]         kind;
        logic               last;
        logic               ok;
        logic               tls;
        logic signed [16:0] port;
    } tagged_byte_t;

    // Tracks the URL parser state and holds the tagged bytes still to come back.
    class url_split_scoreboard;
        wsus_phase_t   phase;
        logic [2:0]    scheme_pos;
        logic          secure;
        wsus_pphase_t  pphase;
        logic          negative;
        int unsigned   accum;
        tagged_byte_t  tagged_bytes_due[$];
        int unsigned   failures;

        function new();
            clear_url();
            failures = 0;
        endfunction

        function void clear_url();
            phase      = PH_SCHEME;
            scheme_pos = 3'd0;
            secure     = 1'b0;
            pphase     = PP_SKIP;
            negative   = 1'b0;
            accum      = 0;
        endfunction

        function void note_accepted_byte(logic [7:0] ch, logic last);
            tagged_byte_t want;
            logic         hit;
            logic         is_digit;
            logic         consumed;
            logic [16:0]  mag;
            want      = '0;
            want.ch   = ch;
            want.last = last;
            want.kind = KIND_OTHER;
            case (phase)
                PH_SCHEME:
                begin
                    // A third character of 's' switches the match over to wss://.
                    if (scheme_pos == 3'd2 && ch == CH_S)
                    begin
                        secure = 1'b1;
                        hit    = 1'b1;
                    end
                    else if (secure)
                        hit = scheme_pos < SCHEME_LEN_WSS && ch == WSS_PREFIX[scheme_pos];
                    else
                        hit = scheme_pos < SCHEME_LEN_WS && ch == WS_PREFIX[scheme_pos];
                    if (!hit)
                        phase = PH_FAIL;
                    else
                    begin
                        scheme_pos = scheme_pos + 3'd1;
                        if (scheme_pos == (secure ? SCHEME_LEN_WSS : SCHEME_LEN_WS))
                        begin
                            phase = PH_HOST;
                            accum = secure ? PORT_DEF_WSS : PORT_DEF_WS;
                        end
                    end
                end
                PH_HOST:
                begin
                    if (ch == CH_COLON)
                    begin
                        phase    = PH_PORT;
                        accum    = 0;
                        negative = 1'b0;
                        pphase   = PP_SKIP;
                    end
                    else if (ch == CH_SLASH)
                    begin
                        phase     = PH_PATH;
                        want.kind = KIND_PATH;
                    end
                    else
                        want.kind = KIND_HOST;
                end
                PH_PORT:
                begin
                    if (ch == CH_SLASH)
                    begin
                        phase     = PH_PATH;
                        want.kind = KIND_PATH;
                    end
                    else
                    begin
                        want.kind = KIND_PORT;
                        is_digit  = ch >= CH_ZERO && ch <= CH_NINE;
                        consumed  = 1'b0;
                        if (pphase == PP_SKIP)
                        begin
                            if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR))
                                consumed = 1'b1;
                            else if (ch == CH_PLUS || ch == CH_MINUS)
                            begin
                                negative = ch == CH_MINUS;
                                pphase   = PP_DIGITS;
                                consumed = 1'b1;
                            end
                            else
                                pphase = is_digit ? PP_DIGITS : PP_DONE;
                        end
                        if (!consumed && pphase == PP_DIGITS)
                        begin
                            if (is_digit)
                            begin
                                accum = accum * 10 + (ch - CH_ZERO);
                                if (accum > PORT_MAX)
                                    accum = PORT_MAX;
                            end
                            else
                                pphase = PP_DONE;
                        end
                    end
                end
                PH_PATH:
                    want.kind = KIND_PATH;
                default:
                    want.kind = KIND_OTHER;
            endcase
            if (last)
            begin
                if (phase == PH_PATH)
                begin
                    mag       = accum[16:0];
                    want.ok   = 1'b1;
                    want.tls  = secure;
                    want.port = negative ? 17'd0 - mag : mag;
                end
                clear_url();
            end
            tagged_bytes_due.push_back(want);
        endfunction

        function void check_tagged_byte(logic [7:0] ch, logic [1:0] kind, logic last,
                                        logic ok, logic tls, logic signed [16:0] port);
            tagged_byte_t want;
            if (tagged_bytes_due.size() == 0)
            begin
                $error("result beat with nothing outstanding: char_out %0d", ch);
                failures++;
                return;
            end
            want = tagged_bytes_due.pop_front();
            if (ch !== want.ch)
            begin
                $error("char_out: expected %0d, actual %0d", want.ch, ch);
                failures++;
            end
            if (kind !== want.kind)
            begin
                $error("byte_kind: expected %0d, actual %0d", want.kind, kind);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("url_end: expected %0d, actual %0d", want.last, last);
                failures++;
            end
            if (ok !== want.ok)
            begin
                $error("parse_ok: expected %0d, actual %0d", want.ok, ok);
                failures++;
            end
            if (tls !== want.tls)
            begin
                $error("tls_on: expected %0d, actual %0d", want.tls, tls);
                failures++;
            end
            if (port !== want.port)
            begin
                $error("port_number: expected %0d, actual %0d", want.port, port);
                failures++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [7:0]         char_in   = 8'h00;
    logic               is_last   = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         char_out;
    logic [1:0]         byte_kind;
    logic               url_end;
    logic               parse_ok;
    logic               tls_on;
    logic signed [16:0] port_number;

    url_split_scoreboard sb = new();
    int unsigned bytes_accepted = 0;
    int unsigned burst_left     = 0;

    websocket_url_splitter_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_in     (char_in),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .byte_kind   (byte_kind),
        .url_end     (url_end),
        .parse_ok    (parse_ok),
        .tls_on      (tls_on),
        .port_number (port_number)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void append_text(ref logic [7:0] url[$], input string text);
        for (int i = 0; i < text.len(); i++)
            url.push_back(text[i]);
    endfunction

    // Mostly well-formed URLs with random content; the rest is noise, a broken
    // scheme, an unclosed port or a URL cut short at a random byte.
    function automatic void make_random_url(ref logic [7:0] url[$]);
        int unsigned shape;
        int unsigned cut;
        logic [7:0]  ch;
        url.delete();
        shape = $urandom_range(0, 99);
        if (shape < 8)
        begin
            repeat ($urandom_range(1, 8))
                url.push_back(8'($urandom_range(0, 255)));
            return;
        end
        append_text(url, $urandom_range(0, 1) ? WSS_PREFIX : WS_PREFIX);
        if (shape < 16)
            url[$urandom_range(0, url.size() - 1)] = 8'($urandom_range(0, 255));
        repeat ($urandom_range(0, 6))
        begin
            do
                ch = 8'($urandom_range(0, 255));
            while (ch == CH_COLON || ch == CH_SLASH);
            url.push_back(ch);
        end
        if ($urandom_range(0, 1))
        begin
            url.push_back(CH_COLON);
            repeat ($urandom_range(0, 2))
                url.push_back($urandom_range(0, 1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4)));
            case ($urandom_range(0, 2))
                1: url.push_back(CH_PLUS);
                2: url.push_back(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(0, 7))
                url.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            repeat ($urandom_range(0, 1))
            begin
                do
                    ch = 8'($urandom_range(0, 255));
                while (ch == CH_SLASH);
                url.push_back(ch);
            end
        end
        if ($urandom_range(0, 9) != 0)
        begin
            url.push_back(CH_SLASH);
            repeat ($urandom_range(0, 6))
                url.push_back(8'($urandom_range(0, 255)));
        end
        if (shape >= 92)
        begin
            cut = $urandom_range(1, url.size());
            while (url.size() > cut)
                void'(url.pop_back());
        end
    endfunction

    // Offers one input beat and waits for it to be taken. A new burst starts
    // after a random gap, during which in_valid is low.
    task automatic send_byte(input logic [7:0] ch, input logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        char_in  <= ch;
        is_last  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_accepted_byte(ch, last);
        bytes_accepted++;
    endtask

    task automatic send_url(input logic [7:0] url[$]);
        foreach (url[i])
            send_byte(url[i], i == url.size() - 1);
    endtask

    initial
    begin : stimulus
        logic [7:0] url[$];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone top-value byte: scheme mismatch on the very first byte.
        url.delete();
        url.push_back(8'hFF);
        send_url(url);
        // Empty host straight into the path, default port 80.
        url.delete();
        append_text(url, "ws:///");
        send_url(url);
        // Secure scheme with a port that holds no digits, which reads as zero.
        url.delete();
        append_text(url, "wss://:/");
        send_url(url);
        // A zero byte in the host and a negative port beyond the saturation limit.
        url.delete();
        append_text(url, WS_PREFIX);
        url.push_back(8'h00);
        append_text(url, ":-70000/");
        send_url(url);

        while (bytes_accepted < ITEM_TARGET)
        begin
            make_random_url(url);
            send_url(url);
        end
        in_valid <= 1'b0;

        while (sb.tagged_bytes_due.size() != 0)
            @(posedge clk);
        // Any result beat turning up now has no prediction and is flagged.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // The receiver cycles through stall patterns, each held for a random stretch.
    // Once, after a few hundred input beats, it holds off long enough for the
    // block to fill up and push back on the sender.
    initial
    begin : result_sink
        sink_mode_t  mode;
        int unsigned mode_left;
        int unsigned tick;
        logic        take;
        logic        hold_done;
        mode      = SINK_OPEN;
        mode_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (!hold_done && bytes_accepted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:     take = 1'b1;
                    SINK_COIN:     take = $urandom_range(0, 1);
                    SINK_SPARSE:   take = $urandom_range(0, 3) == 0;
                    SINK_PERIODIC: take = (tick % 3) != 0;
                    default:       take = 1'b1;
                endcase
                out_ready <= take;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_tagged_byte(char_out, byte_kind, url_end, parse_ok, tls_on, port_number);
    end

    // Ends the run if neither side moves a beat for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/wsus_pkg.sv
rtl/wsus_port_reader.sv
rtl/wsus_step.sv
rtl/websocket_url_splitter_core.sv
rtl/wsus_checker.sv
sim/tb.sv
